>>> design/ucfg_pkg.sv
package ucfg_pkg;

	localparam logic [7:0] TYPE_CONFIG = 8'h02;
	localparam logic [7:0] TYPE_INTERFACE = 8'h04;
	localparam logic [7:0] TYPE_ENDPOINT = 8'h05;
	localparam logic [7:0] CONFIG_SIZE = 8'd9;
	localparam logic [7:0] INTERFACE_SIZE = 8'd9;
	localparam logic [7:0] ENDPOINT_SIZE = 8'd7;
	localparam logic [1:0] XFER_INTERRUPT = 2'b11;
	localparam int DIR_IN_BIT = 7;
	localparam logic [16:0] OFFSET_MAX = 17'h1FFFF;

	localparam logic [10:0] MIN_IN_RESET = 11'd64;
	localparam logic [10:0] MIN_OUT_RESET = 11'd63;
	localparam logic [7:0] CLASS_RESET = 8'h03;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_INVALID = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_MIN_IN = 2'd0,
		REG_MIN_OUT = 2'd1,
		REG_CLASS = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [10:0] min_in;
		logic [10:0] min_out;
		logic [7:0] tclass;
	} cfg_t;

	typedef struct packed {
		status_t status;
		logic [7:0] config_val;
		logic [7:0] num_interfaces;
		logic [7:0] intf_number;
		logic [7:0] alt_setting;
		logic [7:0] in_address;
		logic [7:0] in_interval;
		logic [10:0] in_packet_size;
		logic out_found;
		logic [7:0] out_address;
		logic [7:0] out_interval;
		logic [10:0] out_packet_size;
	} result_t;

endpackage

>>> design/ucfg_parser.sv
module ucfg_parser import ucfg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input logic [7:0] data_byte,
	input logic last_byte,
	input cfg_t cfg,
	output logic res_push,
	output result_t res
);

	typedef struct packed {
		logic [16:0] off;
		logic [15:0] tlen;
		logic [7:0] hlen;
		logic [7:0] dlen;
		logic [7:0] dleft;
		logic is_intf;
		logic is_ep;
		logic [7:0] s0;
		logic [7:0] s1;
		logic [7:0] s2;
		logic [2:0] s3;
		logic class_act;
		logic stop;
		logic perr;
		logic [7:0] intf_num;
		logic [7:0] alt;
		logic in_found;
		logic [7:0] in_addr;
		logic [7:0] in_ival;
		logic [10:0] in_size;
		logic out_found;
		logic [7:0] out_addr;
		logic [7:0] out_ival;
		logic [10:0] out_size;
		logic [7:0] cval;
		logic [7:0] count;
	} state_t;

	state_t st_q;
	state_t w;
	state_t st_d;
	logic walk;
	logic [7:0] idx;
	logic [15:0] rem;
	logic [15:0] new_tlen;
	logic [10:0] ep_size;
	logic [17:0] avail;
	logic invalid;

	always_comb begin
		w = st_q;
		walk = !st_q.perr && !st_q.stop &&
			(st_q.off < 17'd4 || st_q.off < {1'b0, st_q.tlen});
		idx = st_q.dlen - st_q.dleft;
		rem = st_q.tlen - st_q.off[15:0];
		new_tlen = {data_byte, st_q.s0};
		ep_size = {st_q.s3, st_q.s2};
		if (walk) begin
			if (st_q.dleft == 8'd0) begin
				if (st_q.off == 17'd0) begin
					w.hlen = data_byte;
					if (data_byte < CONFIG_SIZE) begin
						w.perr = 1'b1;
					end else begin
						w.dlen = data_byte;
						w.dleft = data_byte - 8'd1;
					end
				end else if (rem < 16'd2 || data_byte < 8'd2 || {8'd0, data_byte} > rem) begin
					w.perr = 1'b1;
				end else begin
					w.dlen = data_byte;
					w.dleft = data_byte - 8'd1;
				end
			end else begin
				w.dleft = st_q.dleft - 8'd1;
				if (idx == 8'd1) begin
					w.is_intf = (data_byte == TYPE_INTERFACE);
					w.is_ep = (data_byte == TYPE_ENDPOINT);
					if (st_q.off == 17'd1 && data_byte != TYPE_CONFIG) begin
						w.perr = 1'b1;
					end else if (data_byte == TYPE_INTERFACE) begin
						if (st_q.dlen < INTERFACE_SIZE) begin
							w.perr = 1'b1;
						end else if (st_q.class_act && st_q.in_found) begin
							w.stop = 1'b1;
						end
					end else if (data_byte == TYPE_ENDPOINT && st_q.class_act &&
						st_q.dlen < ENDPOINT_SIZE) begin
						w.perr = 1'b1;
					end
				end else begin
					if (idx == 8'd2) w.s0 = data_byte;
					if (idx == 8'd3) w.s1 = data_byte;
					if (idx == 8'd4) w.s2 = data_byte;
					if (idx == 8'd5) w.s3 = data_byte[2:0];
					if (st_q.off == 17'd3) begin
						w.tlen = new_tlen;
						if (new_tlen < {8'd0, st_q.hlen}) w.perr = 1'b1;
					end
					if (st_q.off == 17'd4) w.count = data_byte;
					if (st_q.off == 17'd5) w.cval = data_byte;
					if (st_q.is_intf && idx == 8'd5) begin
						w.class_act = (data_byte == cfg.tclass);
						w.in_found = 1'b0;
						w.out_found = 1'b0;
						if (data_byte == cfg.tclass) begin
							w.intf_num = st_q.s0;
							w.alt = st_q.s1;
						end
					end else if (st_q.is_ep && st_q.class_act && idx == 8'd6 &&
						st_q.s1[1:0] == XFER_INTERRUPT) begin
						if (st_q.s0[DIR_IN_BIT]) begin
							if (!st_q.in_found && ep_size >= cfg.min_in) begin
								w.in_found = 1'b1;
								w.in_addr = st_q.s0;
								w.in_ival = data_byte;
								w.in_size = ep_size;
							end
						end else if (!st_q.out_found && ep_size >= cfg.min_out) begin
							w.out_found = 1'b1;
							w.out_addr = st_q.s0;
							w.out_ival = data_byte;
							w.out_size = ep_size;
						end
					end
				end
			end
		end
		if (st_q.off != OFFSET_MAX) w.off = st_q.off + 17'd1;

		avail = {1'b0, st_q.off} + 18'd1;
		invalid = avail < {10'd0, CONFIG_SIZE} || w.perr || {2'd0, w.tlen} > avail;
		res = '0;
		if (invalid) begin
			res.status = ST_INVALID;
		end else begin
			res.config_val = w.cval;
			res.num_interfaces = w.count;
			if (!w.class_act || !w.in_found) begin
				res.status = ST_NOT_FOUND;
			end else begin
				res.status = ST_OK;
				res.intf_number = w.intf_num;
				res.alt_setting = w.alt;
				res.in_address = w.in_addr;
				res.in_interval = w.in_ival;
				res.in_packet_size = w.in_size;
				if (w.out_found) begin
					res.out_found = 1'b1;
					res.out_address = w.out_addr;
					res.out_interval = w.out_ival;
					res.out_packet_size = w.out_size;
				end
			end
		end

		res_push = fire && last_byte;
		if (!fire) begin
			st_d = st_q;
		end else if (last_byte) begin
			st_d = '0;
		end else begin
			st_d = w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else begin
			st_q <= st_d;
		end
	end

endmodule

>>> design/usb_config_descriptor_endpoint_finder.sv
// Parses a USB configuration descriptor fed one byte per item, the final byte
// flagged by last_byte, and reports the first interrupt IN and OUT endpoints
// of the interface whose class matches the class register. One byte is taken
// every clock cycle while in_ready is high; each byte updates the walk state
// in a single register stage. The result for the flagged byte is registered
// in the output register, or in one skid stage while the output stalls, so
// in_ready falls only when two results wait untaken. The three registers sit
// on the APB port at byte addresses 0x0, 0x4 and 0x8; the user must write them
// only while no buffer is in flight, as the block itself does not enforce it.
module usb_config_descriptor_endpoint_finder import ucfg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic last_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] status,
	output logic [7:0] config_val,
	output logic [7:0] num_interfaces,
	output logic [7:0] intf_number,
	output logic [7:0] alt_setting,
	output logic [7:0] in_address,
	output logic [7:0] in_interval,
	output logic [10:0] in_packet_size,
	output logic out_found,
	output logic [7:0] out_address,
	output logic [7:0] out_interval,
	output logic [10:0] out_packet_size
);

	cfg_t cfg_q;
	reg_idx_t reg_idx;
	logic fire;
	logic res_push;
	result_t res;
	result_t out_q;
	result_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;
	logic out_stall;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_in <= MIN_IN_RESET;
			cfg_q.min_out <= MIN_OUT_RESET;
			cfg_q.tclass <= CLASS_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_MIN_IN: cfg_q.min_in <= pwdata[10:0];
				REG_MIN_OUT: cfg_q.min_out <= pwdata[10:0];
				REG_CLASS: cfg_q.tclass <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MIN_IN: prdata = {21'd0, cfg_q.min_in};
			REG_MIN_OUT: prdata = {21'd0, cfg_q.min_out};
			REG_CLASS: prdata = {24'd0, cfg_q.tclass};
			default: prdata = 32'd0;
		endcase
	end

	assign in_ready = !skid_valid_q;
	assign fire = in_valid && in_ready;

	ucfg_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.cfg(cfg_q),
		.res_push(res_push),
		.res(res)
	);

	assign out_stall = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_stall) begin
			if (res_push) skid_valid_q <= 1'b1;
		end else if (skid_valid_q) begin
			out_valid_q <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res_push;
		end
	end

	always_ff @(posedge clk) begin
		if (out_stall) begin
			if (res_push) skid_q <= res;
		end else if (skid_valid_q) begin
			out_q <= skid_q;
		end else if (res_push) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_q.status;
	assign config_val = out_q.config_val;
	assign num_interfaces = out_q.num_interfaces;
	assign intf_number = out_q.intf_number;
	assign alt_setting = out_q.alt_setting;
	assign in_address = out_q.in_address;
	assign in_interval = out_q.in_interval;
	assign in_packet_size = out_q.in_packet_size;
	assign out_found = out_q.out_found;
	assign out_address = out_q.out_address;
	assign out_interval = out_q.out_interval;
	assign out_packet_size = out_q.out_packet_size;

endmodule
